// ----- design/hctm_pkg.sv -----
// shared types and constants for the hsv color threshold mask
// no dependencies; imported by hsv_color_threshold_mask
package hctm_pkg;

  // hue in 1/64 degree: one sector spans 60 degrees, a full turn 360 degrees
  localparam int unsigned HUE_SCALE = 3840;
  localparam int unsigned HUE_FULL  = 6 * HUE_SCALE;
  localparam int unsigned HUE_W     = 15;
  localparam int unsigned QUO_W     = 12;
  localparam int unsigned NUM_W     = 20;

  // restoring divider: bits per stage and stage count
  localparam int unsigned DIV_BITS  = 3;
  localparam int unsigned DIV_STEPS = QUO_W / DIV_BITS;

  // stage 0 min/max, stage 1 numerator, divider stages, hue stage, output stage
  localparam int unsigned NUM_STAGES = DIV_STEPS + 4;
  localparam int unsigned HUE_STAGE  = DIV_STEPS + 2;
  localparam int unsigned OUT_STAGE  = DIV_STEPS + 3;

  // configuration register indexes
  localparam logic [2:0] REG_RANGE_COUNT = 3'd0;
  localparam logic [2:0] REG_RANGE0_LOW  = 3'd1;
  localparam logic [2:0] REG_RANGE0_HIGH = 3'd2;
  localparam logic [2:0] REG_RANGE1_LOW  = 3'd3;
  localparam logic [2:0] REG_RANGE1_HIGH = 3'd4;
  localparam logic [2:0] REG_SAT_MIN     = 3'd5;
  localparam logic [2:0] REG_VAL_MIN     = 3'd6;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // fields carried alongside the division
  typedef struct packed {
    sector_t    sector;
    logic       neg;
    logic       zero;
    logic       sat_ok;
    logic       val_ok;
    logic [7:0] delta;
  } pass_t;

  // first stage result
  typedef struct packed {
    sector_t    sector;
    logic       neg;
    logic [7:0] num;
    logic [7:0] delta;
    logic [7:0] vmax;
  } mm_t;

  function automatic logic hue_in_range(input logic [HUE_W-1:0] hue,
                                        input logic [HUE_W-1:0] lo,
                                        input logic [HUE_W-1:0] hi);
    logic res;
    if (lo <= hi) begin
      res = (hue >= lo) && (hue <= hi);
    end else begin
      res = (hue >= lo) || (hue <= hi);
    end
    return res;
  endfunction

endpackage

// ----- design/hsv_color_threshold_mask.sv -----
// rgb pixel to hsv color class mask, pipelined one pixel per clock while the output is not stalled
// depends on hctm_pkg (types, constants, range compare)
//
// One pixel in, one mask bit out, in order. The pipeline holds eight
// register stages: min/max and sector, numerator scaling with the saturation
// and value tests, four stages of a restoring divider at three quotient bits
// each, hue assembly, and the range compare that feeds the output register.
// A new pixel is taken every cycle while the output is not stalled. Each
// stage holds its data when the next one is full and stalled, so
// backpressure on the output fills the bubbles first and then stops the input.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata and must only
// change while no pixel is in flight; indexes above six are ignored.
module hsv_color_threshold_mask (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // mask_on [0], zeros above
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [14:0] cfg_wdata
);
  import hctm_pkg::*;

  // configuration registers
  logic [1:0]       range_count_r;
  logic [HUE_W-1:0] range0_low_r, range0_high_r, range1_low_r, range1_high_r;
  logic [8:0]       sat_min_r;
  logic [7:0]       val_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_count_r <= 2'd1;
      range0_low_r  <= '0;
      range0_high_r <= HUE_W'(HUE_FULL - 1);
      range1_low_r  <= '0;
      range1_high_r <= HUE_W'(HUE_FULL - 1);
      sat_min_r     <= '0;
      val_min_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RANGE_COUNT: range_count_r <= cfg_wdata[1:0];
        REG_RANGE0_LOW:  range0_low_r  <= cfg_wdata;
        REG_RANGE0_HIGH: range0_high_r <= cfg_wdata;
        REG_RANGE1_LOW:  range1_low_r  <= cfg_wdata;
        REG_RANGE1_HIGH: range1_high_r <= cfg_wdata;
        REG_SAT_MIN:     sat_min_r     <= cfg_wdata[8:0];
        REG_VAL_MIN:     val_min_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // valid bits and per-stage advance
  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_tready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !valid_r[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (adv[i]) begin
          valid_r[i] <= (i == 0) ? in_tvalid : valid_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign in_tready = adv[0];

  // stage 0: max, min, sector and signed numerator
  logic [7:0] red, green, blue;
  mm_t        mm_nxt, mm_r;

  assign red   = in_tdata[7:0];
  assign green = in_tdata[15:8];
  assign blue  = in_tdata[23:16];

  always_comb begin
    logic [7:0] vmax, vmin, pos, ngv;
    vmax = red;
    vmin = red;
    if (green > vmax) vmax = green;
    if (blue > vmax)  vmax = blue;
    if (green < vmin) vmin = green;
    if (blue < vmin)  vmin = blue;
    // ties go red, then green, then blue
    if (vmax == red) begin
      mm_nxt.sector = SEC_RED;
      pos = green;
      ngv = blue;
    end else if (vmax == green) begin
      mm_nxt.sector = SEC_GREEN;
      pos = blue;
      ngv = red;
    end else begin
      mm_nxt.sector = SEC_BLUE;
      pos = red;
      ngv = green;
    end
    mm_nxt.neg   = pos < ngv;
    mm_nxt.num   = (pos < ngv) ? ngv - pos : pos - ngv;
    mm_nxt.delta = vmax - vmin;
    mm_nxt.vmax  = vmax;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) mm_r <= mm_nxt;
  end

  // stage 1 and divider stages share these arrays; index 0 is loaded by stage 1
  logic [7:0]       dv_rem_r [DIV_STEPS+1];
  logic [QUO_W-1:0] dv_low_r [DIV_STEPS+1];
  logic [QUO_W-1:0] dv_q_r   [DIV_STEPS+1];
  pass_t            ps_r     [DIV_STEPS+1];

  // stage 1: numerator times 3840, saturation and value tests
  logic [NUM_W-1:0] numer;
  logic [16:0]      sat_lhs, sat_rhs;
  pass_t            ps_nxt;

  assign numer   = ({mm_r.num, 12'd0}) - ({4'd0, mm_r.num, 8'd0});
  assign sat_lhs = {1'b0, mm_r.delta, 8'd0};
  assign sat_rhs = {8'd0, sat_min_r} * {9'd0, mm_r.vmax};

  always_comb begin
    ps_nxt.sector = mm_r.sector;
    ps_nxt.neg    = mm_r.neg;
    ps_nxt.zero   = (mm_r.delta == 8'd0);
    ps_nxt.sat_ok = (mm_r.delta == 8'd0) ? (sat_min_r == 9'd0) : (sat_lhs >= sat_rhs);
    ps_nxt.val_ok = mm_r.vmax >= val_min_r;
    ps_nxt.delta  = mm_r.delta;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      // numerator is at most 3840 * delta, so its top byte is already below delta
      dv_rem_r[0] <= numer[NUM_W-1:QUO_W];
      dv_low_r[0] <= numer[QUO_W-1:0];
      dv_q_r[0]   <= '0;
      ps_r[0]     <= ps_nxt;
    end
  end

  // restoring divider, three quotient bits per stage
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [7:0]       rem_nxt;
    logic [QUO_W-1:0] q_nxt;

    always_comb begin
      logic [8:0] trial;
      rem_nxt = dv_rem_r[j-1];
      q_nxt   = dv_q_r[j-1];
      for (int b = 0; b < DIV_BITS; b++) begin
        trial = {rem_nxt, dv_low_r[j-1][QUO_W - 1 - (j - 1) * DIV_BITS - b]};
        if (trial >= {1'b0, ps_r[j-1].delta}) begin
          trial = trial - {1'b0, ps_r[j-1].delta};
          q_nxt = {q_nxt[QUO_W-2:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[QUO_W-2:0], 1'b0};
        end
        rem_nxt = trial[7:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[j+1]) begin
        dv_rem_r[j] <= rem_nxt;
        dv_low_r[j] <= dv_low_r[j-1];
        dv_q_r[j]   <= q_nxt;
        ps_r[j]     <= ps_r[j-1];
      end
    end
  end

  // hue stage: zero for a grey pixel, else base plus floor, or base minus ceiling
  pass_t            ps_f;
  logic [QUO_W:0]   quo_ceil;
  logic [HUE_W-1:0] base, hue_nxt, hue_r;
  logic             ok_r;

  assign ps_f     = ps_r[DIV_STEPS];
  assign quo_ceil = {1'b0, dv_q_r[DIV_STEPS]} + {{QUO_W{1'b0}}, dv_rem_r[DIV_STEPS] != 8'd0};

  always_comb begin
    case (ps_f.sector)
      SEC_RED:   base = '0;
      SEC_GREEN: base = HUE_W'(2 * HUE_SCALE);
      SEC_BLUE:  base = HUE_W'(4 * HUE_SCALE);
      default:   base = '0;
    endcase
    if (ps_f.zero) begin
      hue_nxt = '0;
    end else if (!ps_f.neg) begin
      hue_nxt = base + {{(HUE_W-QUO_W){1'b0}}, dv_q_r[DIV_STEPS]};
    end else if (ps_f.sector == SEC_RED) begin
      // negative red sector wraps below zero
      hue_nxt = HUE_W'(HUE_FULL) - {{(HUE_W-QUO_W-1){1'b0}}, quo_ceil};
    end else begin
      hue_nxt = base - {{(HUE_W-QUO_W-1){1'b0}}, quo_ceil};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[HUE_STAGE]) begin
      hue_r <= hue_nxt;
      ok_r  <= ps_f.sat_ok && ps_f.val_ok;
    end
  end

  // output stage: hue range compare
  logic hue_ok, mask_r;

  assign hue_ok = ((range_count_r != 2'd0) &&
                   hue_in_range(hue_r, range0_low_r, range0_high_r)) ||
                  (range_count_r[1] &&
                   hue_in_range(hue_r, range1_low_r, range1_high_r));

  always_ff @(posedge clk) begin
    if (adv[OUT_STAGE]) mask_r <= ok_r && hue_ok;
  end

  assign out_tvalid = valid_r[OUT_STAGE];
  assign out_tdata  = {7'd0, mask_r};

  // checks
  a_rem_below_delta: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[HUE_STAGE-1] && !ps_f.zero |-> dv_rem_r[DIV_STEPS] < ps_f.delta)
    else $error("divider remainder not below delta");

  // a tie for the largest channel gives a full sector of 3840
  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[HUE_STAGE-1] && !ps_f.zero |-> dv_q_r[DIV_STEPS] <= QUO_W'(HUE_SCALE))
    else $error("sector quotient out of range");

  a_hue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[HUE_STAGE] |-> hue_r < HUE_W'(HUE_FULL))
    else $error("hue out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[OUT_STAGE] && !out_tready |=> valid_r[OUT_STAGE] && $stable(mask_r))
    else $error("stalled result changed");

endmodule
